// ----- rtl/stfp_pkg.sv -----
// shared types and constants of the signed triple frame parser
package stfp_pkg;

   localparam int TaskLen  = 2;
   localparam int FieldLen = 4;

   // register indexes of the csr port
   typedef enum logic [1:0] {
      REG_START      = 2'd0,
      REG_FIRST_SEP  = 2'd1,
      REG_SECOND_SEP = 2'd2,
      REG_END        = 2'd3
   } reg_index_type;

   localparam logic [7:0] START_CHAR_RESET      = 8'h40;
   localparam logic [7:0] FIRST_SEP_CHAR_RESET  = 8'h21;
   localparam logic [7:0] SECOND_SEP_CHAR_RESET = 8'h7C;
   localparam logic [7:0] END_CHAR_RESET        = 8'h23;

   // raw characters of one closed frame
   typedef struct packed {
      logic [TaskLen-1:0][7:0]  task_chars;
      logic [FieldLen-1:0][7:0] field_a_chars;
      logic [FieldLen-1:0][7:0] field_b_chars;
   } frame_type;

   // delimiter bytes as configured
   typedef struct packed {
      logic [7:0] start_char;
      logic [7:0] first_sep_char;
      logic [7:0] second_sep_char;
      logic [7:0] end_char;
   } delim_type;

endpackage

// ----- rtl/stfp_front.sv -----
// front end: tracks frame phase, collects field bytes, pushes closed frames
module stfp_front
   import stfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  delim_type  delims,
   input  logic       byte_accept,
   input  logic [7:0] rx_byte,
   output logic       push,
   output frame_type  push_frame
);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_TASK    = 2'd1,
      PH_FIELD_A = 2'd2,
      PH_FIELD_B = 2'd3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] count_ff, count_in;
   frame_type  frame_ff, frame_in;
   logic       push_in;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      frame_in = frame_ff;
      push_in  = 1'b0;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (rx_byte == delims.start_char) begin
                  frame_in = '0;
                  phase_in = PH_TASK;
                  count_in = '0;
               end
            end
            PH_TASK: begin
               if (rx_byte == delims.first_sep_char) begin
                  phase_in = PH_FIELD_A;
                  count_in = '0;
               end else if (count_ff < 3'(TaskLen)) begin
                  frame_in.task_chars[count_ff[0]] = rx_byte;
                  count_in = count_ff + 3'd1;
               end
            end
            PH_FIELD_A: begin
               if (rx_byte == delims.second_sep_char) begin
                  phase_in = PH_FIELD_B;
                  count_in = '0;
               end else if (count_ff < 3'(FieldLen)) begin
                  frame_in.field_a_chars[count_ff[1:0]] = rx_byte;
                  count_in = count_ff + 3'd1;
               end
            end
            PH_FIELD_B: begin
               if (rx_byte == delims.end_char) begin
                  // frame closed, push the buffers into the queue for the back end
                  push_in  = 1'b1;
                  phase_in = PH_IDLE;
                  count_in = '0;
               end else if (count_ff < 3'(FieldLen)) begin
                  frame_in.field_b_chars[count_ff[1:0]] = rx_byte;
                  count_in = count_ff + 3'd1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         frame_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         frame_ff <= frame_in;
      end
   end

   assign push       = push_in;
   assign push_frame = frame_ff;

endmodule

// ----- rtl/stfp_queue.sv -----
// short frame queue between front and back end
module stfp_queue
   import stfp_pkg::*;
#(
   parameter int Depth = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_frame,
   input  logic      pop,
   output frame_type head_frame,
   output logic      not_empty,
   output logic      full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   frame_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
      next_ptr = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign head_frame = entry_ff[rd_ptr_ff];
   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == CntW'(Depth));

endmodule

// ----- rtl/stfp_back.sv -----
// back end: decodes queued frames, keeps held values, drives the result register
module stfp_back
   import stfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  frame_type          head_frame,
   input  logic               head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_task_number,
   output logic signed [10:0] rsp_value_a,
   output logic signed [10:0] rsp_value_b,
   output logic               rsp_value_a_fresh,
   output logic               rsp_value_b_fresh
);

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;

   logic               valid_ff, valid_in;
   logic [6:0]         task_ff, task_in;
   logic signed [10:0] held_a_ff, held_a_in;
   logic signed [10:0] held_b_ff, held_b_in;
   logic               fresh_a_ff, fresh_a_in;
   logic               fresh_b_ff, fresh_b_in;
   logic [3:0]         task_tens, task_units;
   logic signed [10:0] dec_a, dec_b;
   logic               sign_a, sign_b;

   // non-digit bytes count as zero
   function automatic logic [3:0] digit_of(input logic [7:0] c);
      digit_of = (c >= CharZero && c <= CharNine) ? 4'(c - CharZero) : 4'd0;
   endfunction

   function automatic logic signed [10:0] field_value(input logic [FieldLen-1:0][7:0] f);
      logic [9:0] mag;
      mag = 10'(digit_of(f[1])) * 10'd100 + 10'(digit_of(f[2])) * 10'd10
            + 10'(digit_of(f[3]));
      field_value = (f[0] == CharMinus) ? 11'sd0 - $signed({1'b0, mag})
                                        : $signed({1'b0, mag});
   endfunction

   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      task_tens  = digit_of(head_frame.task_chars[0]);
      task_units = digit_of(head_frame.task_chars[1]);
      sign_a     = (head_frame.field_a_chars[0] == CharPlus)
                   || (head_frame.field_a_chars[0] == CharMinus);
      sign_b     = (head_frame.field_b_chars[0] == CharPlus)
                   || (head_frame.field_b_chars[0] == CharMinus);
      dec_a      = field_value(head_frame.field_a_chars);
      dec_b      = field_value(head_frame.field_b_chars);

      valid_in   = valid_ff && !rsp_ready;
      task_in    = task_ff;
      held_a_in  = held_a_ff;
      held_b_in  = held_b_ff;
      fresh_a_in = fresh_a_ff;
      fresh_b_in = fresh_b_ff;
      if (pop) begin
         valid_in   = 1'b1;
         task_in    = 7'(task_tens) * 7'd10 + 7'(task_units);
         // missing sign keeps the held value
         held_a_in  = sign_a ? dec_a : held_a_ff;
         held_b_in  = sign_b ? dec_b : held_b_ff;
         fresh_a_in = sign_a;
         fresh_b_in = sign_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         held_a_ff <= '0;
         held_b_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         held_a_ff <= held_a_in;
         held_b_ff <= held_b_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff    <= task_in;
      fresh_a_ff <= fresh_a_in;
      fresh_b_ff <= fresh_b_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_task_number   = task_ff;
   assign rsp_value_a       = held_a_ff;
   assign rsp_value_b       = held_b_ff;
   assign rsp_value_a_fresh = fresh_a_ff;
   assign rsp_value_b_fresh = fresh_b_ff;

endmodule

// ----- rtl/ascii_signed_triple_frame_parser_core.sv -----
// top level of the signed triple frame parser: csr registers and the three stages
//
//   channel  direction  beat
//   req      in         one received byte (req_rx_byte)
//   rsp      out        task number, two signed values, two fresh flags
//   csr      in/out     apb-style access to the four delimiter bytes
//
// one byte is taken every cycle while the frame queue has room
// a result passes through the frame queue and then the output register once its end byte is taken
// reset is synchronous; all delimiters return to their defaults, held values clear
// a stalled rsp fills the output register then the queue, after which req_ready drops
module ascii_signed_triple_frame_parser_core
   import stfp_pkg::*;
#(
   parameter int QueueDepth = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_task_number,
   output logic signed [10:0] rsp_value_a,
   output logic signed [10:0] rsp_value_b,
   output logic               rsp_value_a_fresh,
   output logic               rsp_value_b_fresh,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   delim_type     delims_ff, delims_in;
   reg_index_type reg_sel;
   logic          csr_write;
   logic          byte_accept;
   logic          push;
   frame_type     push_frame;
   frame_type     head_frame;
   logic          head_valid;
   logic          queue_full;
   logic          pop;

   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      delims_in = delims_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_START:      delims_in.start_char      = pwdata[7:0];
            REG_FIRST_SEP:  delims_in.first_sep_char  = pwdata[7:0];
            REG_SECOND_SEP: delims_in.second_sep_char = pwdata[7:0];
            REG_END:        delims_in.end_char        = pwdata[7:0];
            default:        delims_in = delims_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_START:      prdata = {24'd0, delims_ff.start_char};
         REG_FIRST_SEP:  prdata = {24'd0, delims_ff.first_sep_char};
         REG_SECOND_SEP: prdata = {24'd0, delims_ff.second_sep_char};
         REG_END:        prdata = {24'd0, delims_ff.end_char};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delims_ff.start_char      <= START_CHAR_RESET;
         delims_ff.first_sep_char  <= FIRST_SEP_CHAR_RESET;
         delims_ff.second_sep_char <= SECOND_SEP_CHAR_RESET;
         delims_ff.end_char        <= END_CHAR_RESET;
      end else begin
         delims_ff <= delims_in;
      end
   end

   assign req_ready   = !queue_full;
   assign byte_accept = req_valid && req_ready;

   stfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .delims      (delims_ff),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .push        (push),
      .push_frame  (push_frame)
   );

   stfp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .not_empty  (head_valid),
      .full       (queue_full)
   );

   stfp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_frame        (head_frame),
      .head_valid        (head_valid),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_task_number   (rsp_task_number),
      .rsp_value_a       (rsp_value_a),
      .rsp_value_b       (rsp_value_b),
      .rsp_value_a_fresh (rsp_value_a_fresh),
      .rsp_value_b_fresh (rsp_value_b_fresh)
   );

endmodule

// ----- tb/sv/tb_ascii_signed_triple_frame_parser_core.sv -----
// testbench for the signed triple frame parser core: directed and random frames, checked per beat
module tb_ascii_signed_triple_frame_parser_core;
   import stfp_pkg::*;

   typedef enum logic [1:0] {
      WAIT_START = 2'd0,
      IN_TASK    = 2'd1,
      IN_FIELD_A = 2'd2,
      IN_FIELD_B = 2'd3
   } parse_phase_type;

   typedef struct packed {
      logic [6:0]  task_number;
      logic [10:0] value_a;
      logic [10:0] value_b;
      logic        a_fresh;
      logic        b_fresh;
   } frame_result_type;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam int RandomBytes = 1500;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [6:0]         rsp_task_number;
   logic signed [10:0] rsp_value_a;
   logic signed [10:0] rsp_value_b;
   logic               rsp_value_a_fresh;
   logic               rsp_value_b_fresh;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [3:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   ascii_signed_triple_frame_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_task_number   (rsp_task_number),
      .rsp_value_a       (rsp_value_a),
      .rsp_value_b       (rsp_value_b),
      .rsp_value_a_fresh (rsp_value_a_fresh),
      .rsp_value_b_fresh (rsp_value_b_fresh),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // parser mirror
   logic [7:0]                delim_cfg [4];
   parse_phase_type           parse_state;
   int                        char_count;
   logic [TaskLen-1:0][7:0]   task_chars;
   logic [FieldLen-1:0][7:0]  field_a_chars;
   logic [FieldLen-1:0][7:0]  field_b_chars;
   logic [10:0]               held_a;
   logic [10:0]               held_b;

   frame_result_type pending_frames [$];
   int               error_count;
   int               bytes_sent;
   bit               steady;
   bit               reset_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("** ascii_signed_triple_frame_parser_core: FAILED **");
      $finish;
   end

   function automatic int digit_val(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) begin
         return int'(c - CH_ZERO);
      end
      return 0;
   endfunction

   task automatic decode_field(input logic [FieldLen-1:0][7:0] f, inout logic [10:0] held,
                               output logic fresh);
      int mag;
      int neg;
      mag = digit_val(f[1]) * 100 + digit_val(f[2]) * 10 + digit_val(f[3]);
      neg = -mag;
      fresh = 1'b1;
      if (f[0] == CH_PLUS) begin
         held = mag[10:0];
      end else if (f[0] == CH_MINUS) begin
         held = neg[10:0];
      end else begin
         fresh = 1'b0;
      end
   endtask

   // advances the mirror by one accepted byte and queues a decoded frame on the end byte
   task automatic parse_byte(input logic [7:0] b);
      frame_result_type r;
      int t;
      case (parse_state)
         WAIT_START: begin
            if (b == delim_cfg[REG_START]) begin
               task_chars    = '0;
               field_a_chars = '0;
               field_b_chars = '0;
               parse_state   = IN_TASK;
               char_count    = 0;
            end
         end
         IN_TASK: begin
            if (b == delim_cfg[REG_FIRST_SEP]) begin
               parse_state = IN_FIELD_A;
               char_count  = 0;
            end else if (char_count < TaskLen) begin
               task_chars[char_count] = b;
               char_count++;
            end
         end
         IN_FIELD_A: begin
            if (b == delim_cfg[REG_SECOND_SEP]) begin
               parse_state = IN_FIELD_B;
               char_count  = 0;
            end else if (char_count < FieldLen) begin
               field_a_chars[char_count] = b;
               char_count++;
            end
         end
         default: begin
            if (b != delim_cfg[REG_END]) begin
               if (char_count < FieldLen) begin
                  field_b_chars[char_count] = b;
                  char_count++;
               end
            end else begin
               parse_state = WAIT_START;
               char_count  = 0;
               t = digit_val(task_chars[0]) * 10 + digit_val(task_chars[1]);
               r.task_number = t[6:0];
               decode_field(field_a_chars, held_a, r.a_fresh);
               decode_field(field_b_chars, held_b, r.b_fresh);
               r.value_a = held_a;
               r.value_b = held_b;
               pending_frames.push_back(r);
            end
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      parse_byte(b);
      bytes_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   // one csr transfer that ends with psel low before the next, so psel is never dropped and raised in one step
   task automatic csr_access(input logic wr, input reg_index_type idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_delims();
      logic [31:0] rd;
      for (int i = 0; i < 4; i++) begin
         csr_access(1'b0, reg_index_type'(i), 32'h0, rd);
         if (rd[7:0] !== delim_cfg[i]) begin
            error_count++;
            if (error_count <= 10) begin
               $display("csr read mismatch: reg %0d expected %02h got %02h", i,
                        delim_cfg[i], rd[7:0]);
            end
         end
      end
   endtask

   task automatic set_delims(input logic [7:0] s, input logic [7:0] f, input logic [7:0] sc,
                             input logic [7:0] e);
      logic [7:0]  vals [4];
      logic [31:0] rd;
      vals = '{s, f, sc, e};
      for (int i = 0; i < 4; i++) begin
         csr_access(1'b1, reg_index_type'(i), {24'h0, vals[i]}, rd);
         delim_cfg[i] = vals[i];
      end
      check_delims();
   endtask

   // lets the stream drain so the block is idle before a csr write or the end
   task automatic wait_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_frames.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      if (pending_frames.size() != 0) begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0d decoded frames never appeared", pending_frames.size());
         end
         pending_frames.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   // result side: random stall per beat, then compare with the oldest decoded frame
   initial begin
      frame_result_type got;
      frame_result_type want;
      int stall;
      wait (reset_done);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         repeat (stall) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = {rsp_task_number, rsp_value_a, rsp_value_b, rsp_value_a_fresh,
                rsp_value_b_fresh};
         if (pending_frames.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected result: task %0d a %0d b %0d fresh %b%b",
                        got.task_number, $signed(got.value_a), $signed(got.value_b),
                        got.a_fresh, got.b_fresh);
            end
         end else begin
            want = pending_frames.pop_front();
            if (got.task_number !== want.task_number || got.value_a !== want.value_a ||
                got.value_b !== want.value_b || got.a_fresh !== want.a_fresh ||
                got.b_fresh !== want.b_fresh) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: expected task %0d a %0d b %0d fresh %b%b",
                           want.task_number, $signed(want.value_a), $signed(want.value_b),
                           want.a_fresh, want.b_fresh);
                  $display("          actual   task %0d a %0d b %0d fresh %b%b",
                           got.task_number, $signed(got.value_a), $signed(got.value_b),
                           got.a_fresh, got.b_fresh);
               end
            end
         end
      end
   end

   task automatic test_reset_values();
      delim_cfg[REG_START]      = START_CHAR_RESET;
      delim_cfg[REG_FIRST_SEP]  = FIRST_SEP_CHAR_RESET;
      delim_cfg[REG_SECOND_SEP] = SECOND_SEP_CHAR_RESET;
      delim_cfg[REG_END]        = END_CHAR_RESET;
      check_delims();
   endtask

   task automatic test_directed_frames();
      // held values are still zero, signs missing
      send_string("@4!123|#");
      // noise and an end byte before the start are ignored
      send_string("x#@99!+999|-999#");
      send_string("@7!5|x#");
      send_string("@00!-000|+000#");
      send_string("@a9!+1x3|-:/9#");
      send_string("@123!+12345|-98765#");
      send_string("@@1!+@12|-3@4#");
      send_string("@!|#");
      wait_idle();
   endtask

   task automatic test_equal_delimiters();
      set_delims(8'h40, 8'h40, 8'h40, 8'h40);
      send_string("@12@+345@-678@");
      send_string("@@@@");
      wait_idle();
   endtask

   task automatic test_extreme_delimiters();
      logic [7:0] seq [] = '{8'h00, "1", "2", 8'hFF, "+", "9", "9", "9", 8'h00,
                             "-", "0", "0", "1", 8'hFF};
      set_delims(8'h00, 8'hFF, 8'h00, 8'hFF);
      foreach (seq[i]) send_byte(seq[i]);
      wait_idle();
      set_delims(8'hFF, 8'h00, 8'hFF, 8'h00);
      foreach (seq[i]) send_byte(~seq[i]);
      wait_idle();
   endtask

   function automatic logic [7:0] rand_digit();
      if ($urandom_range(0, 7) != 0) begin
         return CH_ZERO + 8'($urandom_range(0, 9));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_signed_field(ref logic [7:0] q [$]);
      int r;
      int n;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         q.push_back(CH_PLUS);
      end else if (r < 8) begin
         q.push_back(CH_MINUS);
      end else if (r == 8) begin
         q.push_back(8'($urandom_range(0, 255)));
      end
      n = ($urandom_range(0, 7) < 5) ? 3 : $urandom_range(0, 5);
      repeat (n) q.push_back(rand_digit());
   endtask

   // mostly complete frames with random content; a truncated one garbles what follows
   task automatic send_random_frame(input bit complete);
      logic [7:0] q [$];
      int n;
      q.push_back(delim_cfg[REG_START]);
      n = ($urandom_range(0, 7) < 6) ? 2 : $urandom_range(0, 3);
      repeat (n) q.push_back(rand_digit());
      q.push_back(delim_cfg[REG_FIRST_SEP]);
      push_signed_field(q);
      q.push_back(delim_cfg[REG_SECOND_SEP]);
      push_signed_field(q);
      q.push_back(delim_cfg[REG_END]);
      if (!complete) begin
         n = $urandom_range(1, q.size() - 1);
         while (q.size() > n) void'(q.pop_back());
      end
      foreach (q[i]) send_byte(q[i]);
   endtask

   task automatic send_noise();
      logic [7:0] b;
      repeat ($urandom_range(1, 6)) begin
         b = 8'($urandom_range(0, 255));
         if (b == delim_cfg[REG_START]) begin
            b = ~b;
         end
         send_byte(b);
      end
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int phase_end;
      int cfg_round;
      int r;
      logic [7:0] s, f, sc, e;
      stop_at   = bytes_sent + RandomBytes;
      cfg_round = 0;
      while (bytes_sent < stop_at) begin
         wait_idle();
         case (cfg_round)
            0: set_delims(START_CHAR_RESET, FIRST_SEP_CHAR_RESET, SECOND_SEP_CHAR_RESET,
                          END_CHAR_RESET);
            1: set_delims(8'h00, 8'hFF, 8'hFF, 8'h00);
            default: begin
               s  = 8'($urandom_range(0, 255));
               f  = ($urandom_range(0, 5) == 0) ? s : 8'($urandom_range(0, 255));
               sc = ($urandom_range(0, 5) == 0) ? f : 8'($urandom_range(0, 255));
               e  = ($urandom_range(0, 5) == 0) ? sc : 8'($urandom_range(0, 255));
               set_delims(s, f, sc, e);
            end
         endcase
         cfg_round++;
         steady    = ($urandom_range(0, 3) == 0);
         phase_end = bytes_sent + 250;
         while (bytes_sent < phase_end) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
               send_random_frame(1'b1);
            end else if (r == 7) begin
               send_random_frame(1'b0);
            end else begin
               send_noise();
            end
         end
         steady = 1'b0;
      end
      wait_idle();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      rsp_ready   <= 1'b0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= 4'h0;
      pwdata      <= 32'h0;
      parse_state   = WAIT_START;
      char_count    = 0;
      task_chars    = '0;
      field_a_chars = '0;
      field_b_chars = '0;
      held_a        = '0;
      held_b        = '0;
      error_count   = 0;
      bytes_sent    = 0;
      steady        = 1'b0;
      reset_done    = 1'b0;
      repeat (11) @(posedge clock);
      reset      <= 1'b0;
      reset_done = 1'b1;
      @(posedge clock);

      test_reset_values();
      test_directed_frames();
      test_equal_delimiters();
      test_extreme_delimiters();
      test_random_traffic();

      if (error_count == 0) begin
         $display("** ascii_signed_triple_frame_parser_core: PASSED **");
      end else begin
         $display("** ascii_signed_triple_frame_parser_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/stfp_pkg.sv
rtl/stfp_front.sv
rtl/stfp_queue.sv
rtl/stfp_back.sv
rtl/ascii_signed_triple_frame_parser_core.sv
tb/sv/tb_ascii_signed_triple_frame_parser_core.sv
